>>> hw/rtl/quad_motor_duty_stepper_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef QUAD_MOTOR_DUTY_STEPPER_MACROS_SVH
`define QUAD_MOTOR_DUTY_STEPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QMDS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qmds assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QMDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qmds assertion failed");

`endif

>>> hw/rtl/qmds_pkg.sv
`default_nettype none

package qmds_pkg;

    localparam int DUTY_WIDTH = 16;
    localparam int CFG_W      = 16;
    localparam int SUM_W      = ((DUTY_WIDTH > CFG_W) ? DUTY_WIDTH : CFG_W) + 1;
    localparam int MOTORS     = 4;

    typedef logic [DUTY_WIDTH-1:0]             t_duty;
    typedef logic [MOTORS-1:0][DUTY_WIDTH-1:0] t_duty_set;
    typedef logic [SUM_W-1:0]                  t_sum;
    typedef logic [CFG_W-1:0]                  t_word;

    localparam logic [1:0] REQ_SINGLE   = 2'd0;
    localparam logic [1:0] REQ_FLIGHT   = 2'd1;
    localparam logic [1:0] REQ_ATTITUDE = 2'd2;

    localparam logic [1:0] OP_STOP = 2'd0;
    localparam logic [1:0] OP_MAX  = 2'd1;
    localparam logic [1:0] OP_UP   = 2'd2;
    localparam logic [1:0] OP_DOWN = 2'd3;

    localparam logic [7:0] ACT_UP      = 8'd0;
    localparam logic [7:0] ACT_DOWN    = 8'd1;
    localparam logic [7:0] ACT_LEFT    = 8'd2;
    localparam logic [7:0] ACT_RIGHT   = 8'd3;
    localparam logic [7:0] ACT_FORWARD = 8'd4;
    localparam logic [7:0] ACT_BACK    = 8'd5;

    localparam logic [2:0] CFG_STEP     = 3'd0;
    localparam logic [2:0] CFG_MAX      = 3'd1;
    localparam logic [2:0] CFG_MIN      = 3'd2;
    localparam logic [2:0] CFG_STOP     = 3'd3;
    localparam logic [2:0] CFG_ANG_HIGH = 3'd4;
    localparam logic [2:0] CFG_ANG_LOW  = 3'd5;

    typedef struct packed {
        t_word              step;
        t_word              max;
        t_word              min;
        t_word              stop;
        logic signed [15:0] ang_high;
        logic signed [15:0] ang_low;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [1:0]         motor_index;
        logic [1:0]         motor_op;
        logic [7:0]         action_code;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } t_req;

    function automatic t_duty to_duty(input t_word v);
        t_sum w;
        w = SUM_W'(v);
        return w[DUTY_WIDTH-1:0];
    endfunction

    function automatic logic [15:0] to_out(input t_duty d);
        t_sum w;
        w = SUM_W'(d);
        return w[15:0];
    endfunction

    function automatic t_duty step_up(input t_duty d, input t_word step, input t_word max);
        t_sum w;
        w = SUM_W'(d) + SUM_W'(step);
        if (w >= SUM_W'(max)) begin
            w = SUM_W'(max);
        end
        return w[DUTY_WIDTH-1:0];
    endfunction

    function automatic t_duty step_down(input t_duty d, input t_word step, input t_word min);
        t_sum w;
        t_sum lim;
        lim = SUM_W'(min) + SUM_W'(step);
        if (SUM_W'(d) <= lim) begin
            w = SUM_W'(min);
        end else begin
            w = SUM_W'(d) - SUM_W'(step);
        end
        return w[DUTY_WIDTH-1:0];
    endfunction

    function automatic t_duty ramp_zero(input t_duty d, input t_word step);
        t_sum w;
        if (SUM_W'(d) <= SUM_W'(step)) begin
            w = '0;
        end else begin
            w = SUM_W'(d) - SUM_W'(step);
        end
        return w[DUTY_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/qmds_regs.sv
`default_nettype none

module qmds_regs (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [2:0]           i_wr_index,
    input  wire logic [15:0]          i_wr_data,
    output qmds_pkg::t_cfg            o_cfg
);

    qmds_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step     <= 16'd10;
            r_cfg.max      <= 16'd1000;
            r_cfg.min      <= 16'd0;
            r_cfg.stop     <= 16'd0;
            r_cfg.ang_high <= 16'sd3000;
            r_cfg.ang_low  <= -16'sd3000;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                qmds_pkg::CFG_STEP:     r_cfg.step     <= i_wr_data;
                qmds_pkg::CFG_MAX:      r_cfg.max      <= i_wr_data;
                qmds_pkg::CFG_MIN:      r_cfg.min      <= i_wr_data;
                qmds_pkg::CFG_STOP:     r_cfg.stop     <= i_wr_data;
                qmds_pkg::CFG_ANG_HIGH: r_cfg.ang_high <= $signed(i_wr_data);
                qmds_pkg::CFG_ANG_LOW:  r_cfg.ang_low  <= $signed(i_wr_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> hw/rtl/qmds_core.sv
`default_nettype none

module qmds_core (
    input  wire qmds_pkg::t_cfg      i_cfg,
    input  wire qmds_pkg::t_req      i_req,
    input  wire qmds_pkg::t_duty_set i_duty,
    output qmds_pkg::t_duty_set      o_duty,
    output logic                     o_fault
);

    qmds_pkg::t_duty mx;
    qmds_pkg::t_duty mx_down;
    qmds_pkg::t_duty sel;
    qmds_pkg::t_duty single_val;
    logic            bad;

    assign mx      = qmds_pkg::to_duty(i_cfg.max);
    assign mx_down = qmds_pkg::step_down(mx, i_cfg.step, i_cfg.min);
    assign sel     = i_duty[i_req.motor_index];

    assign bad = (i_req.pitch_angle >= i_cfg.ang_high) || (i_req.pitch_angle <= i_cfg.ang_low)
              || (i_req.roll_angle >= i_cfg.ang_high) || (i_req.roll_angle <= i_cfg.ang_low);

    always_comb begin
        unique case (i_req.motor_op)
            qmds_pkg::OP_STOP: single_val = qmds_pkg::to_duty(i_cfg.stop);
            qmds_pkg::OP_MAX:  single_val = mx;
            qmds_pkg::OP_UP:   single_val = qmds_pkg::step_up(sel, i_cfg.step, i_cfg.max);
            default:           single_val = qmds_pkg::step_down(sel, i_cfg.step, i_cfg.min);
        endcase
    end

    always_comb begin
        o_duty  = i_duty;
        o_fault = 1'b0;
        unique case (i_req.req_type)
            qmds_pkg::REQ_SINGLE: begin
                o_duty[i_req.motor_index] = single_val;
            end
            qmds_pkg::REQ_FLIGHT: begin
                unique case (i_req.action_code)
                    qmds_pkg::ACT_UP: o_duty = {mx, mx, mx, mx};
                    qmds_pkg::ACT_DOWN: begin
                        for (int m = 0; m < qmds_pkg::MOTORS; m++) begin
                            o_duty[m] = qmds_pkg::step_down(i_duty[m], i_cfg.step, i_cfg.min);
                        end
                    end
                    qmds_pkg::ACT_LEFT:    o_duty = {mx_down, mx, mx, mx_down};
                    qmds_pkg::ACT_RIGHT:   o_duty = {mx, mx_down, mx_down, mx};
                    qmds_pkg::ACT_FORWARD: o_duty = {mx, mx, mx_down, mx_down};
                    qmds_pkg::ACT_BACK:    o_duty = {mx_down, mx_down, mx, mx};
                    default: begin
                        for (int m = 0; m < qmds_pkg::MOTORS; m++) begin
                            o_duty[m] = qmds_pkg::ramp_zero(i_duty[m], i_cfg.step);
                        end
                    end
                endcase
            end
            qmds_pkg::REQ_ATTITUDE: begin
                if (bad) begin
                    o_duty  = {mx, mx, mx, mx};
                    o_fault = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/quad_motor_duty_stepper.sv
// Four-motor duty controller. Request words enter on i_valid/o_ready with
// one field per port; each word updates the four held duties and yields one
// result word on o_valid/i_ready carrying all four duties and the tilt flag.
// Registers are written through i_cfg_valid/o_cfg_ready with a 3-bit index
// and 16-bit data; o_cfg_ready is always high and writes are expected only
// while no request is in flight.
// A request is captured in an input register; once the result register is
// empty or being read, the duty update is computed and written to the duty
// and result registers, which then offer the result word.
// Throughput is one word per cycle while the receiver keeps up, as the
// four duty registers are updated together.
// When the receiver stalls, the result word holds and the input register
// keeps the one waiting word; o_ready drops only when both are occupied.
// Synchronous reset empties both stages, clears all duties to zero and
// loads the register defaults.
`default_nettype none
`include "quad_motor_duty_stepper_macros.svh"

module quad_motor_duty_stepper (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [1:0]         i_motor_index,
    input  wire logic [1:0]         i_motor_op,
    input  wire logic [7:0]         i_action_code,
    input  wire logic signed [15:0] i_pitch_angle,
    input  wire logic signed [15:0] i_roll_angle,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [15:0]             o_duty_one,
    output logic [15:0]             o_duty_two,
    output logic [15:0]             o_duty_three,
    output logic [15:0]             o_duty_four,
    output logic                    o_tilt_fault,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    qmds_pkg::t_cfg      cfg;
    qmds_pkg::t_req      r_req;
    logic                r_req_vld;
    qmds_pkg::t_duty_set r_duty;
    qmds_pkg::t_duty_set n_duty;
    logic                r_out_vld;
    logic                r_fault;
    logic                n_fault;
    logic                advance;
    logic                duties_equal;

    assign o_cfg_ready = 1'b1;

    qmds_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    qmds_core u_core (
        .i_cfg   (cfg),
        .i_req   (r_req),
        .i_duty  (r_duty),
        .o_duty  (n_duty),
        .o_fault (n_fault)
    );

    assign advance = r_req_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_req_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else if (o_ready) begin
            r_req_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.req_type    <= i_req_type;
            r_req.motor_index <= i_motor_index;
            r_req.motor_op    <= i_motor_op;
            r_req.action_code <= i_action_code;
            r_req.pitch_angle <= i_pitch_angle;
            r_req.roll_angle  <= i_roll_angle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duty    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (advance) begin
                r_duty    <= n_duty;
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fault <= n_fault;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_duty_one   = qmds_pkg::to_out(r_duty[0]);
    assign o_duty_two   = qmds_pkg::to_out(r_duty[1]);
    assign o_duty_three = qmds_pkg::to_out(r_duty[2]);
    assign o_duty_four  = qmds_pkg::to_out(r_duty[3]);
    assign o_tilt_fault = r_fault;

    assign duties_equal = (r_duty[0] == r_duty[1]) && (r_duty[1] == r_duty[2])
                       && (r_duty[2] == r_duty[3]);

    `QMDS_ASSERT_NEXT(a_advance_gives_result, i_clk, i_rst_n, advance, r_out_vld)
    `QMDS_ASSERT_NEXT(a_duty_only_on_advance, i_clk, i_rst_n, !advance, $stable(r_duty))
    `QMDS_ASSERT_SAME(a_stall_means_full, i_clk, i_rst_n, !o_ready, r_req_vld && r_out_vld)
    `QMDS_ASSERT_SAME(a_fault_all_equal, i_clk, i_rst_n, r_out_vld && r_fault, duties_equal)

endmodule

`default_nettype wire
